// ===== rtl/cxyh_pkg.sv =====
// Shared types and constants of the CoreXY stepper homing controller.
// Used by the channel interfaces, the homing step unit, the top level and the checker.
package cxyh_pkg;

  // Field widths fixed by the item and result formats
  localparam int unsigned STEP_W      = 14;
  localparam int unsigned DUTY_W      = 6;
  localparam int unsigned SHORT_W     = 8;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 14;

  // duty*255/100 as a multiply by a scaled reciprocal of 100 (exact for duty below 64)
  localparam int unsigned PWM_SCALE = 255;
  localparam int unsigned PWM_RECIP = 5243;
  localparam int unsigned PWM_SHIFT = 19;

  // Full-step coil patterns, bit 3 drives IN1
  localparam logic [3:0] COIL_TABLE [4] = '{4'hA, 4'h6, 4'h5, 4'h9};

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STEP_INTERVAL   = 3'd0,
    CFG_DUTY_PERCENT    = 3'd1,
    CFG_DRIVERS_ENABLED = 3'd2,
    CFG_HOME_MAX_STEPS  = 3'd3,
    CFG_HOME_BACKOFF    = 3'd4,
    CFG_HOME_RELEASE    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_HOME = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    TGT_MOTOR1 = 2'd0,
    TGT_MOTOR2 = 2'd1,
    TGT_X_AXIS = 2'd2,
    TGT_Y_AXIS = 2'd3
  } target_t;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_MOVING     = 3'd1,
    ST_HOMING     = 3'd2,
    ST_MOVE_DONE  = 3'd3,
    ST_HOME_OK    = 3'd4,
    ST_HOME_FAIL  = 3'd5,
    ST_REJECT_OFF = 3'd6,
    ST_BAD_COUNT  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    HR_NONE    = 2'd0,
    HR_OK      = 2'd1,
    HR_STUCK   = 2'd2,
    HR_TIMEOUT = 2'd3
  } home_res_t;

  // Both axes ok: X result in bits 1:0, Y result in bits 3:2
  localparam logic [3:0] BOTH_AXES_OK = {HR_OK, HR_OK};

  typedef enum logic [1:0] {
    HS_START    = 2'd0,
    HS_RELEASE  = 2'd1,
    HS_APPROACH = 2'd2,
    HS_BACKOFF  = 2'd3
  } home_stage_t;

  // Outcome of one homing step slot, from the homing unit to the top level
  typedef struct packed {
    logic              step;
    logic              m1_fwd;
    logic              m2_fwd;
    logic              done;
    home_stage_t       stage;
    logic              axis;
    logic [STEP_W-1:0] steps;
    logic [3:0]        results;
  } home_upd_t;

  // Input item as held in the input register
  typedef struct packed {
    logic [1:0]        action;
    logic [1:0]        target;
    logic              forward;
    logic [STEP_W-1:0] step_count;
    logic              limit_x_pressed;
    logic              limit_y_pressed;
  } item_t;

endpackage

// ===== rtl/cxyh_if.sv =====
// Valid/ready channel interfaces for command items and result items.
// Widths follow cxyh_pkg.
interface cxyh_item_if
  import cxyh_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [1:0]        target;
  logic              forward;
  logic [STEP_W-1:0] step_count;
  logic              limit_x_pressed;
  logic              limit_y_pressed;

  modport source (output valid, output action, output target, output forward,
                  output step_count, output limit_x_pressed, output limit_y_pressed,
                  input ready);
  modport sink   (input valid, input action, input target, input forward,
                  input step_count, input limit_x_pressed, input limit_y_pressed,
                  output ready);
endinterface

interface cxyh_result_if
  import cxyh_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [3:0]         motor1_coils;
  logic [3:0]         motor2_coils;
  logic [SHORT_W-1:0] pwm_level;
  logic               busy_res;
  logic [2:0]         status;
  logic [1:0]         x_home_result;
  logic [1:0]         y_home_result;

  modport source (output valid, output motor1_coils, output motor2_coils, output pwm_level,
                  output busy_res, output status, output x_home_result,
                  output y_home_result, input ready);
  modport sink   (input valid, input motor1_coils, input motor2_coils, input pwm_level,
                  input busy_res, input status, input x_home_result, input y_home_result,
                  output ready);
endinterface

// ===== rtl/cxyh_home_unit.sv =====
// Homing step slot: resolves the stage chain of the active axis and, when X
// finishes, of Y in the same slot. Depends on cxyh_pkg.
module cxyh_home_unit
  import cxyh_pkg::*;
(
  input  home_stage_t        stage,
  input  logic               axis,
  input  logic [STEP_W-1:0]  steps_left,
  input  logic [3:0]         axis_results,
  input  logic               limit_x_pressed,
  input  logic               limit_y_pressed,
  input  logic [STEP_W-1:0]  home_max_steps,
  input  logic [SHORT_W-1:0] home_backoff_steps,
  input  logic [SHORT_W-1:0] home_release_steps,
  output home_upd_t          upd
);

  typedef struct packed {
    logic              step;
    logic              away;
    logic              done;
    home_res_t         res;
    home_stage_t       stage;
    logic [STEP_W-1:0] steps;
  } axis_eval_t;

  // Walk one axis through its stages until it steps or finishes
  function automatic axis_eval_t eval_axis(input home_stage_t st_in,
                                           input logic [STEP_W-1:0] n_in,
                                           input logic pressed,
                                           input logic [STEP_W-1:0] max_steps,
                                           input logic [SHORT_W-1:0] backoff,
                                           input logic [SHORT_W-1:0] release_n);
    axis_eval_t r;
    r.step  = 1'b0;
    r.away  = 1'b0;
    r.done  = 1'b0;
    r.res   = HR_NONE;
    r.stage = st_in;
    r.steps = n_in;
    if (r.stage == HS_START) begin
      if (pressed) begin
        r.stage = HS_RELEASE;
        r.steps = STEP_W'(release_n);
      end else begin
        r.stage = HS_APPROACH;
        r.steps = max_steps;
      end
    end
    if (r.stage == HS_RELEASE) begin
      if (r.steps != '0) begin
        r.step  = 1'b1;
        r.away  = 1'b1;
        r.steps = r.steps - 1'b1;
      end else if (pressed) begin
        r.done = 1'b1;
        r.res  = HR_STUCK;
      end else begin
        r.stage = HS_APPROACH;
        r.steps = max_steps;
      end
    end
    if (r.stage == HS_APPROACH && !r.step && !r.done) begin
      if (r.steps == '0) begin
        r.done = 1'b1;
        r.res  = HR_TIMEOUT;
      end else if (pressed) begin
        r.stage = HS_BACKOFF;
        r.steps = STEP_W'(backoff);
      end else begin
        r.step  = 1'b1;
        r.steps = r.steps - 1'b1;
      end
    end
    if (r.stage == HS_BACKOFF && !r.step && !r.done) begin
      if (r.steps != '0) begin
        r.step  = 1'b1;
        r.away  = 1'b1;
        r.steps = r.steps - 1'b1;
      end else begin
        r.done = 1'b1;
        r.res  = HR_OK;
      end
    end
    return r;
  endfunction

  axis_eval_t        ev_x;
  axis_eval_t        ev_y;
  home_stage_t       y_stage_in;
  logic [STEP_W-1:0] y_steps_in;
  logic [3:0]        results_x;

  // Y starts fresh when X finishes in this slot
  always_comb begin
    y_stage_in = (axis == 1'b0) ? HS_START : stage;
    y_steps_in = (axis == 1'b0) ? '0 : steps_left;
    ev_x = eval_axis(stage, steps_left, limit_x_pressed,
                     home_max_steps, home_backoff_steps, home_release_steps);
    ev_y = eval_axis(y_stage_in, y_steps_in, limit_y_pressed,
                     home_max_steps, home_backoff_steps, home_release_steps);
    results_x = (axis == 1'b0) ? (axis_results | {2'b00, ev_x.res}) : axis_results;
  end

  // Pick the axis outcome; X toward the switch is motor1 back, motor2 forward
  always_comb begin
    upd = '0;
    if (axis == 1'b0 && !ev_x.done) begin
      upd.step    = 1'b1;
      upd.m1_fwd  = ev_x.away;
      upd.m2_fwd  = !ev_x.away;
      upd.stage   = ev_x.stage;
      upd.axis    = 1'b0;
      upd.steps   = ev_x.steps;
      upd.results = axis_results;
    end else if (!ev_y.done) begin
      upd.step    = 1'b1;
      upd.m1_fwd  = ev_y.away;
      upd.m2_fwd  = ev_y.away;
      upd.stage   = ev_y.stage;
      upd.axis    = 1'b1;
      upd.steps   = ev_y.steps;
      upd.results = results_x;
    end else begin
      upd.done    = 1'b1;
      upd.stage   = HS_START;
      upd.axis    = 1'b0;
      upd.steps   = '0;
      upd.results = results_x | {ev_y.res, 2'b00};
    end
  end

endmodule

// ===== rtl/corexy_stepper_homing_controller.sv =====
// Top level of the CoreXY full-step stepper controller with homing.
// Depends on cxyh_pkg, cxyh_if and cxyh_home_unit.
//
//   channel   dir   handshake      carries
//   item      in    valid/ready    action, target, forward, step_count, limit switches
//   result    out   valid/ready    coils, pwm_level, busy_res, status, home results
//   cfg       in    cfg_we         cfg_index, cfg_data (write only)
//
// One item enters per cycle unless stalled. The transfer loads the input
// register; advance loads the result register. All work for an item sits
// between those two registers. When result.ready is low the result register
// holds and the input register fills, then item.ready drops. Reset loads the
// register defaults and empties both stages; no clearing pass is needed.
module corexy_stepper_homing_controller
  import cxyh_pkg::*;
#(
  parameter int unsigned MAX_STEP_COUNT = 10000
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  cxyh_item_if.sink              item,
  cxyh_result_if.source          result
);

  localparam logic [STEP_W-1:0] CNT_MAX = STEP_W'(MAX_STEP_COUNT);

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_M1, MODE_M2, MODE_X, MODE_Y, MODE_HOME
  } job_mode_t;

  // Configuration registers
  logic [STEP_W-1:0]  step_interval;
  logic [DUTY_W-1:0]  duty_percent;
  logic               drivers_enabled;
  logic [STEP_W-1:0]  home_max_steps;
  logic [SHORT_W-1:0] home_backoff_steps;
  logic [SHORT_W-1:0] home_release_steps;

  // Job state
  logic [1:0]         motor1_phase, motor1_phase_next;
  logic [1:0]         motor2_phase, motor2_phase_next;
  job_mode_t          job_mode, job_mode_next;
  logic [1:0]         job_directions, job_directions_next;
  logic [STEP_W-1:0]  steps_left, steps_left_next;
  logic [STEP_W-1:0]  tick_countdown, tick_countdown_next;
  home_stage_t        home_stage, home_stage_next;
  logic               home_axis, home_axis_next;
  logic [3:0]         axis_results, axis_results_next;

  // Input stage
  logic               s1_valid;
  item_t              s1;
  logic               advance;

  home_upd_t          hu;
  status_t            status_v;
  logic               do_step, m1_en, m1_fwd, m2_en, m2_fwd;
  logic               bad_count;
  logic [STEP_W-1:0]  reload;
  logic [STEP_W-1:0]  pwm_prod;
  logic [26:0]        pwm_scaled;
  logic [SHORT_W-1:0] pwm_v;

  assign advance    = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || advance;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval      <= STEP_W'(8000);
      duty_percent       <= DUTY_W'(60);
      drivers_enabled    <= 1'b0;
      home_max_steps     <= STEP_W'(4000);
      home_backoff_steps <= SHORT_W'(20);
      home_release_steps <= SHORT_W'(50);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_INTERVAL:   step_interval      <= cfg_data;
        CFG_DUTY_PERCENT:    duty_percent       <= cfg_data[DUTY_W-1:0];
        CFG_DRIVERS_ENABLED: drivers_enabled    <= cfg_data[0];
        CFG_HOME_MAX_STEPS:  home_max_steps     <= cfg_data;
        CFG_HOME_BACKOFF:    home_backoff_steps <= cfg_data[SHORT_W-1:0];
        CFG_HOME_RELEASE:    home_release_steps <= cfg_data[SHORT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      s1.action          <= item.action;
      s1.target          <= item.target;
      s1.forward         <= item.forward;
      s1.step_count      <= item.step_count;
      s1.limit_x_pressed <= item.limit_x_pressed;
      s1.limit_y_pressed <= item.limit_y_pressed;
    end
  end

  cxyh_home_unit u_home (
    .stage              (home_stage),
    .axis               (home_axis),
    .steps_left         (steps_left),
    .axis_results       (axis_results),
    .limit_x_pressed    (s1.limit_x_pressed),
    .limit_y_pressed    (s1.limit_y_pressed),
    .home_max_steps     (home_max_steps),
    .home_backoff_steps (home_backoff_steps),
    .home_release_steps (home_release_steps),
    .upd                (hu)
  );

  assign bad_count = (s1.step_count == '0) || (s1.step_count > CNT_MAX);
  assign reload    = (step_interval == '0) ? '0 : step_interval - 1'b1;

  // Work out the next job state and the status of the item
  always_comb begin
    job_mode_next       = job_mode;
    job_directions_next = job_directions;
    steps_left_next     = steps_left;
    tick_countdown_next = tick_countdown;
    home_stage_next     = home_stage;
    home_axis_next      = home_axis;
    axis_results_next   = axis_results;
    status_v            = ST_IDLE;
    do_step             = 1'b0;
    m1_en               = 1'b0;
    m1_fwd              = 1'b0;
    m2_en               = 1'b0;
    m2_fwd              = 1'b0;
    case (s1.action)
      ACT_TICK: begin
        if (job_mode != MODE_IDLE) begin
          if (tick_countdown != '0) begin
            tick_countdown_next = tick_countdown - 1'b1;
          end else if (job_mode == MODE_HOME) begin
            do_step           = hu.step;
            m1_en             = hu.step;
            m2_en             = hu.step;
            m1_fwd            = hu.m1_fwd;
            m2_fwd            = hu.m2_fwd;
            home_stage_next   = hu.stage;
            home_axis_next    = hu.axis;
            steps_left_next   = hu.steps;
            axis_results_next = hu.results;
            if (hu.done) begin
              job_mode_next = MODE_IDLE;
              status_v = (hu.results == BOTH_AXES_OK) ? ST_HOME_OK : ST_HOME_FAIL;
            end
          end else if (steps_left == '0) begin
            job_mode_next = MODE_IDLE;
            status_v      = ST_MOVE_DONE;
          end else begin
            do_step         = 1'b1;
            m1_en           = (job_mode != MODE_M2);
            m2_en           = (job_mode != MODE_M1);
            m1_fwd          = job_directions[0];
            m2_fwd          = job_directions[1];
            steps_left_next = steps_left - 1'b1;
          end
        end
      end
      ACT_MOVE: begin
        if (job_mode == MODE_IDLE) begin
          if (bad_count) begin
            status_v = ST_BAD_COUNT;
          end else if (!drivers_enabled) begin
            status_v = ST_REJECT_OFF;
          end else begin
            case (s1.target)
              TGT_MOTOR1: job_mode_next = MODE_M1;
              TGT_MOTOR2: job_mode_next = MODE_M2;
              TGT_X_AXIS: job_mode_next = MODE_X;
              default:    job_mode_next = MODE_Y;
            endcase
            // X axis runs the motors against each other
            job_directions_next = {(s1.target == TGT_X_AXIS) ? !s1.forward : s1.forward,
                                   s1.forward};
            steps_left_next     = s1.step_count;
            tick_countdown_next = '0;
          end
        end
      end
      ACT_HOME: begin
        if (job_mode == MODE_IDLE) begin
          if (!drivers_enabled) begin
            status_v = ST_REJECT_OFF;
          end else begin
            job_mode_next       = MODE_HOME;
            home_stage_next     = HS_START;
            home_axis_next      = 1'b0;
            axis_results_next   = '0;
            steps_left_next     = '0;
            tick_countdown_next = '0;
          end
        end
      end
      default: ;
    endcase
    if (do_step) begin
      tick_countdown_next = reload;
    end
    if (status_v == ST_IDLE && job_mode_next != MODE_IDLE) begin
      status_v = (job_mode_next == MODE_HOME) ? ST_HOMING : ST_MOVING;
    end
  end

  // Advance the phases of the motors that step
  always_comb begin
    motor1_phase_next = motor1_phase;
    motor2_phase_next = motor2_phase;
    if (m1_en) motor1_phase_next = motor1_phase + (m1_fwd ? 2'd1 : 2'd3);
    if (m2_en) motor2_phase_next = motor2_phase + (m2_fwd ? 2'd1 : 2'd3);
  end

  // PWM level from the duty setting
  assign pwm_prod   = STEP_W'(duty_percent * PWM_SCALE);
  assign pwm_scaled = 27'(pwm_prod * PWM_RECIP);
  assign pwm_v      = SHORT_W'(pwm_scaled >> PWM_SHIFT);

  // Hold job state
  always_ff @(posedge clk) begin
    if (rst) begin
      motor1_phase   <= '0;
      motor2_phase   <= '0;
      job_mode       <= MODE_IDLE;
      job_directions <= '0;
      steps_left     <= '0;
      tick_countdown <= '0;
      home_stage     <= HS_START;
      home_axis      <= 1'b0;
      axis_results   <= '0;
    end else if (advance) begin
      motor1_phase   <= motor1_phase_next;
      motor2_phase   <= motor2_phase_next;
      job_mode       <= job_mode_next;
      job_directions <= job_directions_next;
      steps_left     <= steps_left_next;
      tick_countdown <= tick_countdown_next;
      home_stage     <= home_stage_next;
      home_axis      <= home_axis_next;
      axis_results   <= axis_results_next;
    end
  end

  // Result register: load on advance, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (advance) begin
      result.motor1_coils  <= drivers_enabled ? COIL_TABLE[motor1_phase_next] : 4'h0;
      result.motor2_coils  <= drivers_enabled ? COIL_TABLE[motor2_phase_next] : 4'h0;
      result.pwm_level     <= drivers_enabled ? pwm_v : '0;
      result.busy_res      <= (job_mode_next != MODE_IDLE);
      result.status        <= status_v;
      result.x_home_result <= axis_results_next[1:0];
      result.y_home_result <= axis_results_next[3:2];
    end
  end

endmodule

// ===== rtl/cxyh_checker.sv =====
// Port-level checks of the CoreXY stepper homing controller, bound to the top level.
// Depends on cxyh_pkg.
module cxyh_checker
  import cxyh_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               valid,
  input logic               ready,
  input logic [3:0]         motor1_coils,
  input logic [3:0]         motor2_coils,
  input logic [SHORT_W-1:0] pwm_level,
  input logic               busy_res,
  input logic [2:0]         status
);

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid after reset");

  // A stalled result keeps its status, coils and busy flag
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(status) && $stable(motor1_coils)
                        && $stable(motor2_coils) && $stable(busy_res))
    else $error("stalled result changed");

  // Busy only while a job runs
  a_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> busy_res == (status == ST_MOVING || status == ST_HOMING))
    else $error("busy flag disagrees with status");

  // A rejection for disabled drivers shows coils and PWM off
  a_off: assert property (@(posedge clk) disable iff (rst)
    valid && status == ST_REJECT_OFF |->
      motor1_coils == 4'h0 && motor2_coils == 4'h0 && pwm_level == '0)
    else $error("outputs live while drivers off");

  // While the PWM level is nonzero the coils show a full-step pattern
  a_coils: assert property (@(posedge clk) disable iff (rst)
    valid && pwm_level != '0 |->
      (motor1_coils == COIL_TABLE[0] || motor1_coils == COIL_TABLE[1] ||
       motor1_coils == COIL_TABLE[2] || motor1_coils == COIL_TABLE[3]) &&
      (motor2_coils == COIL_TABLE[0] || motor2_coils == COIL_TABLE[1] ||
       motor2_coils == COIL_TABLE[2] || motor2_coils == COIL_TABLE[3]))
    else $error("coil pattern outside the step table");

endmodule

bind corexy_stepper_homing_controller cxyh_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .valid        (result.valid),
  .ready        (result.ready),
  .motor1_coils (result.motor1_coils),
  .motor2_coils (result.motor2_coils),
  .pwm_level    (result.pwm_level),
  .busy_res     (result.busy_res),
  .status       (result.status)
);

// ===== test/corexy_stepper_homing_controller_tb.sv =====
// Self-checking testbench for corexy_stepper_homing_controller: moves, homing, rejects.
// Needs cxyh_pkg, the cxyh_if channel interfaces and the controller RTL.
module corexy_stepper_homing_controller_tb;
  import cxyh_pkg::*;

  localparam int unsigned MAX_STEPS      = 10000;
  localparam int unsigned RANDOM_ITEMS   = 1150;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TIMEOUT_CYCLES = 1000000;
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;

  typedef enum logic [2:0] {
    JOB_IDLE, JOB_M1, JOB_M2, JOB_X, JOB_Y, JOB_HOME
  } job_t;

  typedef struct packed {
    logic [3:0] m1;
    logic [3:0] m2;
    logic [7:0] pwm;
    logic       busy;
    logic [2:0] status;
    logic [1:0] x_res;
    logic [1:0] y_res;
  } ctrl_result_t;

  // Mirror of the controller state; one expected result per accepted item
  class homing_scoreboard;
    logic [13:0]  interval, max_steps, steps_left, countdown;
    logic [5:0]   duty;
    logic         drv_on;
    logic [7:0]   backoff, rel_steps;
    logic [1:0]   m1_phase, m2_phase, dirs;
    job_t         mode;
    home_stage_t  stage;
    logic         axis;
    logic [3:0]   axis_res;
    ctrl_result_t pending_results[$];
    int unsigned  errors;

    function new();
      interval = 14'd8000;
      duty = 6'd60;
      drv_on = 1'b0;
      max_steps = 14'd4000;
      backoff = 8'd20;
      rel_steps = 8'd50;
      m1_phase = '0;
      m2_phase = '0;
      dirs = '0;
      mode = JOB_IDLE;
      steps_left = '0;
      countdown = '0;
      stage = HS_START;
      axis = 1'b0;
      axis_res = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [13:0] val);
      case (idx)
        CFG_STEP_INTERVAL:   interval = val;
        CFG_DUTY_PERCENT:    duty = val[5:0];
        CFG_DRIVERS_ENABLED: drv_on = val[0];
        CFG_HOME_MAX_STEPS:  max_steps = val;
        CFG_HOME_BACKOFF:    backoff = val[7:0];
        CFG_HOME_RELEASE:    rel_steps = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [3:0] coil_levels(logic [1:0] ph);
      case (ph)
        2'd0:    return 4'b1010;
        2'd1:    return 4'b0110;
        2'd2:    return 4'b0101;
        default: return 4'b1001;
      endcase
    endfunction

    // Advance the selected motors one full step and restart the interval
    function void take_step(logic m1, logic f1, logic m2, logic f2);
      if (m1) m1_phase = f1 ? m1_phase + 2'd1 : m1_phase - 2'd1;
      if (m2) m2_phase = f2 ? m2_phase + 2'd1 : m2_phase - 2'd1;
      countdown = (interval == 0) ? '0 : interval - 14'd1;
    endfunction

    // X toward the switch: motor1 back, motor2 forward; Y toward: both back
    function void home_move(logic toward);
      take_step(1'b1, !toward, 1'b1, (axis == 1'b0) ^ !toward);
    endfunction

    // One homing slot; stages with no motion fall through within the same tick
    function status_t home_slot(logic px, logic py);
      logic      pressed;
      home_res_t res;
      for (int g = 0; g < 12; g++) begin
        pressed = axis ? py : px;
        res = HR_NONE;
        case (stage)
          HS_START: begin
            stage = pressed ? HS_RELEASE : HS_APPROACH;
            steps_left = pressed ? 14'(rel_steps) : max_steps;
            continue;
          end
          HS_RELEASE: begin
            if (steps_left > 0) begin
              home_move(1'b0);
              steps_left--;
              return ST_HOMING;
            end
            if (!pressed) begin
              stage = HS_APPROACH;
              steps_left = max_steps;
              continue;
            end
            res = HR_STUCK;
          end
          HS_APPROACH: begin
            if (steps_left == 0) begin
              res = HR_TIMEOUT;
            end else if (pressed) begin
              stage = HS_BACKOFF;
              steps_left = 14'(backoff);
              continue;
            end else begin
              home_move(1'b1);
              steps_left--;
              return ST_HOMING;
            end
          end
          default: begin
            if (steps_left > 0) begin
              home_move(1'b0);
              steps_left--;
              return ST_HOMING;
            end
            res = HR_OK;
          end
        endcase
        if (axis) axis_res[3:2] = axis_res[3:2] | res;
        else axis_res[1:0] = axis_res[1:0] | res;
        steps_left = '0;
        stage = HS_START;
        if (!axis) begin
          axis = 1'b1;
          continue;
        end
        axis = 1'b0;
        mode = JOB_IDLE;
        return (axis_res == BOTH_AXES_OK) ? ST_HOME_OK : ST_HOME_FAIL;
      end
      return ST_HOMING;
    endfunction

    // Apply one accepted item and queue the result it should produce
    function void note_item(item_t it);
      status_t      st;
      ctrl_result_t r;
      int unsigned  pwm;
      logic         d2;
      st = ST_IDLE;
      case (it.action)
        ACT_TICK: begin
          if (mode != JOB_IDLE) begin
            if (countdown > 0) begin
              countdown--;
            end else if (mode == JOB_HOME) begin
              st = home_slot(it.limit_x_pressed, it.limit_y_pressed);
            end else if (steps_left == 0) begin
              mode = JOB_IDLE;
              st = ST_MOVE_DONE;
            end else begin
              take_step(mode != JOB_M2, dirs[0], mode != JOB_M1, dirs[1]);
              steps_left--;
            end
          end
        end
        ACT_MOVE: begin
          if (mode == JOB_IDLE) begin
            if (it.step_count < 1 || it.step_count > MAX_STEPS) begin
              st = ST_BAD_COUNT;
            end else if (!drv_on) begin
              st = ST_REJECT_OFF;
            end else begin
              d2 = (it.target == TGT_X_AXIS) ? !it.forward : it.forward;
              case (it.target)
                TGT_MOTOR1: mode = JOB_M1;
                TGT_MOTOR2: mode = JOB_M2;
                TGT_X_AXIS: mode = JOB_X;
                default:    mode = JOB_Y;
              endcase
              dirs = {d2, it.forward};
              steps_left = it.step_count;
              countdown = '0;
            end
          end
        end
        ACT_HOME: begin
          if (mode == JOB_IDLE) begin
            if (!drv_on) begin
              st = ST_REJECT_OFF;
            end else begin
              mode = JOB_HOME;
              stage = HS_START;
              axis = 1'b0;
              axis_res = '0;
              steps_left = '0;
              countdown = '0;
            end
          end
        end
        default: ;
      endcase
      if (st == ST_IDLE && mode != JOB_IDLE)
        st = (mode == JOB_HOME) ? ST_HOMING : ST_MOVING;
      pwm = int'(duty) * 255 / 100;
      if (pwm > 255) pwm = 255;
      r.m1 = drv_on ? coil_levels(m1_phase) : 4'd0;
      r.m2 = drv_on ? coil_levels(m2_phase) : 4'd0;
      r.pwm = drv_on ? 8'(pwm) : 8'd0;
      r.busy = (mode != JOB_IDLE);
      r.status = st;
      r.x_res = axis_res[1:0];
      r.y_res = axis_res[3:2];
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] e, logic [7:0] g);
      if (g !== e) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: %s expected %0d got %0d at %0t", name, e, g, $realtime);
      end
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(ctrl_result_t got);
      ctrl_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %h at %0t", got, $realtime);
        return;
      end
      e = pending_results.pop_front();
      compare_field("motor1_coils", e.m1, got.m1);
      compare_field("motor2_coils", e.m2, got.m2);
      compare_field("pwm_level", e.pwm, got.pwm);
      compare_field("busy_res", e.busy, got.busy);
      compare_field("status", e.status, got.status);
      compare_field("x_home_result", e.x_res, got.x_res);
      compare_field("y_home_result", e.y_res, got.y_res);
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  cxyh_item_if   item_if ();
  cxyh_result_if res_if ();

  homing_scoreboard sb;
  int unsigned      gap_pct;
  int unsigned      stall_pct;
  bit               hold_req;
  int unsigned      sent;

  corexy_stepper_homing_controller #(
    .MAX_STEP_COUNT(MAX_STEPS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_if),
    .result    (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watch both channels; every transfer goes to the scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (item_if.valid && item_if.ready)
        sb.note_item('{item_if.action, item_if.target, item_if.forward, item_if.step_count,
                       item_if.limit_x_pressed, item_if.limit_y_pressed});
      if (res_if.valid && res_if.ready)
        sb.check_result('{res_if.motor1_coils, res_if.motor2_coils, res_if.pwm_level,
                          res_if.busy_res, res_if.status, res_if.x_home_result,
                          res_if.y_home_result});
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      res_if.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("FAIL corexy_stepper_homing_controller");
    $finish;
  end

  function automatic logic rbit();
    return 1'($urandom_range(1));
  endfunction

  function automatic item_t mk_item(logic [1:0] act, logic [1:0] tgt, logic fwd,
                                    logic [13:0] cnt, logic px, logic py);
    return '{act, tgt, fwd, cnt, px, py};
  endfunction

  // Tick with random filler in the fields that a tick does not use
  function automatic item_t tick_item(logic px, logic py);
    return mk_item(ACT_TICK, 2'($urandom_range(3)), rbit(), 14'($urandom_range(16383)),
                   px, py);
  endfunction

  // Counts around the valid range edges, out of range, or a short valid run
  function automatic logic [13:0] wild_count();
    case ($urandom_range(5))
      0:       return 14'd0;
      1:       return 14'd1;
      2:       return 14'(MAX_STEPS + 1);
      3:       return 14'h3FFF;
      4:       return 14'($urandom_range(MAX_STEPS + 1, 16383));
      default: return 14'($urandom_range(2, 6));
    endcase
  endfunction

  function automatic item_t rand_item();
    return mk_item(2'($urandom_range(3)), 2'($urandom_range(3)), rbit(), wild_count(),
                   rbit(), rbit());
  endfunction

  function automatic int unsigned pct_pick();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 20;
      2:       return 50;
      default: return 100;
    endcase
  endfunction

  // Idling phases: none, sender only, receiver only, both
  function automatic void set_idling(int unsigned phase);
    case (phase)
      0:       begin gap_pct = 0;  stall_pct = 0;  end
      1:       begin gap_pct = 46; stall_pct = 0;  end
      2:       begin gap_pct = 0;  stall_pct = 46; end
      default: begin gap_pct = 33; stall_pct = 33; end
    endcase
  endfunction

  // Offer one item, with random gaps ahead of it, and hold it until transfer
  task automatic send_item(item_t it);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid           <= 1'b1;
    item_if.action          <= it.action;
    item_if.target          <= it.target;
    item_if.forward         <= it.forward;
    item_if.step_count      <= it.step_count;
    item_if.limit_x_pressed <= it.limit_x_pressed;
    item_if.limit_y_pressed <= it.limit_y_pressed;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [13:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_config(int unsigned iv, int unsigned dp, int unsigned de,
                              int unsigned ms, int unsigned bo, int unsigned rs);
    drain();
    write_reg(CFG_STEP_INTERVAL, 14'(iv));
    write_reg(CFG_DUTY_PERCENT, 14'(dp));
    write_reg(CFG_DRIVERS_ENABLED, 14'(de));
    write_reg(CFG_HOME_MAX_STEPS, 14'(ms));
    write_reg(CFG_HOME_BACKOFF, 14'(bo));
    write_reg(CFG_HOME_RELEASE, 14'(rs));
    cfg_we <= 1'b0;
  endtask

  // Move command followed by about enough ticks to finish it
  task automatic run_move(logic [1:0] tgt, logic fwd, logic [13:0] cnt, int extra);
    int unsigned pace;
    int          n;
    pace = (sb.interval == 0) ? 1 : sb.interval;
    send_item(mk_item(ACT_MOVE, tgt, fwd, cnt, rbit(), rbit()));
    n = (cnt >= 1 && cnt <= MAX_STEPS) ? int'(cnt) * int'(pace) + 1 : 1;
    n = n + extra;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 4) send_item(rand_item());
      else send_item(tick_item(rbit(), rbit()));
    end
  endtask

  // Home command, then ticks with each switch pressed at its own rate
  task automatic run_home(int unsigned px_pct, int unsigned py_pct);
    int unsigned pace;
    int unsigned n;
    pace = (sb.interval == 0) ? 1 : sb.interval;
    n = 2 * (sb.rel_steps + sb.max_steps + sb.backoff + 3) * pace + 2;
    send_item(mk_item(ACT_HOME, 2'($urandom_range(3)), rbit(), wild_count(),
                      rbit(), rbit()));
    repeat (n) begin
      if ($urandom_range(99) < 3) send_item(rand_item());
      else send_item(tick_item($urandom_range(99) < px_pct, $urandom_range(99) < py_pct));
    end
  endtask

  initial begin
    int unsigned pick;
    int unsigned job_no;
    int unsigned rand_start;
    sb = new();
    sent = 0;
    hold_req = 1'b0;
    set_idling(0);
    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_index               <= CFG_STEP_INTERVAL;
    cfg_data                <= '0;
    item_if.valid           <= 1'b0;
    item_if.action          <= ACT_TICK;
    item_if.target          <= TGT_MOTOR1;
    item_if.forward         <= 1'b0;
    item_if.step_count      <= '0;
    item_if.limit_x_pressed <= 1'b0;
    item_if.limit_y_pressed <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, drivers off: count checks come before the drivers check
    set_idling(1);
    send_item(mk_item(ACT_TICK, TGT_Y_AXIS, 1'b1, 14'h3FFF, 1'b1, 1'b1));
    send_item(mk_item(ACT_MOVE, TGT_MOTOR1, 1'b1, 14'd0, 1'b0, 1'b0));
    send_item(mk_item(ACT_MOVE, TGT_X_AXIS, 1'b0, 14'(MAX_STEPS + 1), 1'b0, 1'b0));
    send_item(mk_item(ACT_MOVE, TGT_Y_AXIS, 1'b1, 14'(MAX_STEPS), 1'b0, 1'b0));
    send_item(mk_item(ACT_HOME, TGT_MOTOR1, 1'b0, 14'd5, 1'b1, 1'b0));
    send_item(mk_item(ACT_UNUSED, TGT_Y_AXIS, 1'b1, 14'h3FFF, 1'b1, 1'b1));

    // Zero interval: one step per tick; every move target once
    apply_config(0, 63, 1, 2, 1, 1);
    send_item(mk_item(ACT_MOVE, TGT_MOTOR1, 1'b1, 14'd1, 1'b0, 1'b0));
    repeat (2) send_item(tick_item(1'b0, 1'b0));
    send_item(mk_item(ACT_MOVE, TGT_MOTOR2, 1'b0, 14'd1, 1'b0, 1'b0));
    repeat (2) send_item(tick_item(1'b0, 1'b0));
    send_item(mk_item(ACT_MOVE, TGT_X_AXIS, 1'b1, 14'd2, 1'b0, 1'b0));
    repeat (3) send_item(tick_item(1'b0, 1'b0));
    send_item(mk_item(ACT_MOVE, TGT_Y_AXIS, 1'b0, 14'd1, 1'b0, 1'b0));
    send_item(tick_item(1'b0, 1'b0));
    send_item(mk_item(ACT_HOME, TGT_MOTOR1, 1'b0, 14'd1, 1'b0, 1'b0));
    send_item(tick_item(1'b0, 1'b0));
    // X stuck after release, Y touches then backs off: homing fails overall
    send_item(mk_item(ACT_HOME, TGT_MOTOR1, 1'b0, 14'd0, 1'b1, 1'b0));
    send_item(tick_item(1'b1, 1'b0));
    send_item(tick_item(1'b1, 1'b0));
    send_item(tick_item(1'b0, 1'b1));
    send_item(tick_item(1'b0, 1'b1));

    // Short intervals, low and zero duty, a longer axis move
    set_idling(2);
    apply_config(3, 10, 1, 16383, 255, 255);
    run_move(TGT_MOTOR1, 1'b1, 14'd1, 1);
    set_idling(0);
    apply_config(4, 60, 1, 4000, 20, 50);
    run_move(TGT_MOTOR2, 1'b0, 14'd2, 0);
    apply_config(0, 0, 1, 16383, 255, 255);
    run_move(TGT_Y_AXIS, 1'b1, 14'd25, 1);
    // Release on X ending stuck, then a backoff on Y
    set_idling(3);
    apply_config(0, 45, 1, 16383, 12, 12);
    send_item(mk_item(ACT_HOME, TGT_X_AXIS, 1'b1, 14'd7, 1'b1, 1'b0));
    for (int k = 0; k < 40; k++) send_item(tick_item(k < 13, k >= 19));

    // Random jobs with a fresh setting every few jobs
    rand_start = sent;
    job_no = 0;
    while (sent - rand_start < RANDOM_ITEMS) begin
      if (job_no % 6 == 0) begin
        apply_config($urandom_range(99) < 60 ? $urandom_range(2) : $urandom_range(3, 6),
                     $urandom_range(63), $urandom_range(99) < 85,
                     $urandom_range(10), $urandom_range(4), $urandom_range(4));
        set_idling((job_no / 6) % 4);
      end
      if (job_no == 2) begin
        hold_req = 1'b1;
        repeat (12) send_item(tick_item(rbit(), rbit()));
      end
      pick = $urandom_range(99);
      if (pick < 45)
        run_move(2'($urandom_range(3)), rbit(),
                 $urandom_range(99) < 85 ? 14'($urandom_range(1, 6)) : wild_count(),
                 $urandom_range(99) < 15 ? -2 : int'($urandom_range(2)));
      else if (pick < 80)
        run_home(pct_pick(), pct_pick());
      else
        repeat ($urandom_range(3, 10)) send_item(rand_item());
      job_no++;
    end

    // Let the last results come out
    item_if.valid <= 1'b0;
    for (int w = 0; w < 20000 && sb.pending_results.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      sb.errors++;
      $display("ERROR: %0d expected results never arrived", sb.pending_results.size());
    end
    if (sb.errors == 0)
      $display("PASS corexy_stepper_homing_controller");
    else
      $display("FAIL corexy_stepper_homing_controller");
    $finish;
  end

endmodule
